FILE: sv/sed_pkg.sv
`default_nettype none
package sed_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned SumW = 64;
  localparam int unsigned MagW = 33;
  localparam int unsigned DivW = MagW + 16;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_a;
    logic signed [CoordW-1:0] coord_b;
    logic [CoordW-1:0] scale;
    logic last_element;
  } in_item_t;

  typedef struct packed {
    logic [SumW-1:0] squared_distance;
    logic [CoordW-1:0] distance;
    logic overflow;
  } out_item_t;

  // classified work for the back part
  typedef struct packed {
    logic [MagW-1:0] mag;
    logic [CoordW-1:0] scale;
    logic zero_scale;
    logic last_element;
  } job_t;
endpackage
`default_nettype wire

FILE: sv/sed_if.sv
`default_nettype none
interface sed_in_if;
  import sed_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sed_out_if;
  import sed_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: sv/sed_front.sv
`default_nettype none
module sed_front (
  input  wire logic clk,
  input  wire logic rst_n,
  sed_in_if.sink in_ch,
  output sed_pkg::job_t job_data,
  output logic job_valid,
  input  wire logic job_ready
);
  import sed_pkg::*;

  job_t q_r [QueueDepth];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic signed [MagW-1:0] diff;
  job_t nj;
  logic push, pop;

  always_comb begin
    diff = MagW'(in_ch.data.coord_a) - MagW'(in_ch.data.coord_b);
    nj.mag = diff[MagW-1] ? MagW'(-diff) : MagW'(diff);
    nj.scale = in_ch.data.scale;
    nj.zero_scale = (in_ch.data.scale == '0);
    nj.last_element = in_ch.data.last_element;
  end

  assign in_ch.ready = (cnt_r != 2'(QueueDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign job_valid = (cnt_r != '0);
  assign pop = job_valid && job_ready;
  assign job_data = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= nj;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: sv/sed_back.sv
`default_nettype none
module sed_back (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sed_pkg::job_t job_data,
  input  wire logic job_valid,
  output logic job_ready,
  sed_out_if.source out_ch
);
  import sed_pkg::*;

  typedef enum logic [2:0] {IDLE, DIV, SQ, ACC, ROOT, OUT} state_t;
  state_t state_r;

  logic [DivW-1:0] num_r;
  logic [CoordW:0] rem_r;
  logic [CoordW-1:0] den_r;
  logic [5:0] cnt_r;
  logic [CoordW-1:0] q_r;
  logic [SumW-1:0] sq_r;
  logic [SumW-1:0] sum_r;
  logic sticky_r, last_r, qovf_r;
  logic [SumW-1:0] rrem_r, root_r, bit_r;
  out_item_t res_r;
  logic res_v_r;

  logic [CoordW+1:0] trial;
  logic [SumW:0] add;
  logic [SumW-1:0] rb;

  assign trial = {rem_r, num_r[DivW-1]} - {2'b0, den_r};
  assign add = {1'b0, sum_r} + {1'b0, sq_r};
  assign rb = root_r + bit_r;
  assign job_ready = (state_r == IDLE);
  assign out_ch.valid = res_v_r;
  assign out_ch.data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      sum_r <= '0;
      sticky_r <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state_r != OUT) res_v_r <= 1'b0;
      case (state_r)
        IDLE: if (job_valid) begin
          num_r <= {job_data.mag, 16'b0};
          rem_r <= '0;
          den_r <= job_data.scale;
          cnt_r <= 6'(DivW);
          qovf_r <= job_data.zero_scale;
          last_r <= job_data.last_element;
          state_r <= job_data.zero_scale ? SQ : DIV;
          q_r <= '1;
        end
        DIV: begin
          // one restoring quotient bit per cycle
          if (!trial[CoordW+1]) begin
            rem_r <= trial[CoordW:0];
            num_r <= {num_r[DivW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[CoordW-1:0], num_r[DivW-1]};
            num_r <= {num_r[DivW-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == 6'd1) state_r <= SQ;
        end
        SQ: begin
          if (!qovf_r && num_r[DivW-1:CoordW] != '0) qovf_r <= 1'b1;
          q_r <= (qovf_r || num_r[DivW-1:CoordW] != '0) ? '1 : num_r[CoordW-1:0];
          state_r <= ACC;
          cnt_r <= '0;
        end
        ACC: begin
          if (cnt_r == '0) begin
            sq_r <= SumW'(q_r) * SumW'(q_r);
            cnt_r <= 6'd1;
          end else begin
            sum_r <= add[SumW] ? '1 : add[SumW-1:0];
            sticky_r <= sticky_r | qovf_r | add[SumW];
            if (last_r) begin
              rrem_r <= add[SumW] ? '1 : add[SumW-1:0];
              root_r <= '0;
              bit_r <= SumW'(1) << (SumW-2);
              state_r <= ROOT;
            end else state_r <= IDLE;
          end
        end
        ROOT: begin
          if (bit_r == '0) state_r <= OUT;
          else begin
            if (rrem_r >= rb) begin
              rrem_r <= rrem_r - rb;
              root_r <= (root_r >> 1) + bit_r;
            end else root_r <= root_r >> 1;
            bit_r <= bit_r >> 2;
          end
        end
        OUT: if (!res_v_r || out_ch.ready) begin
          res_r.squared_distance <= sum_r;
          res_r.distance <= root_r[CoordW-1:0];
          res_r.overflow <= sticky_r;
          res_v_r <= 1'b1;
          sum_r <= '0;
          sticky_r <= 1'b0;
          state_r <= IDLE;
        end
        default: state_r <= IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/scaled_euclidean_distance_top.sv
`default_nettype none
// the back part takes one item at a time, through a bit-serial divider of 49 quotient bits;
// a zero scale skips the divider. the last item of a vector
// adds a square root and a load of the output register.
// a two-entry queue takes items while the back part works; the result sits in
// an output register until taken
module scaled_euclidean_distance_top (
  input wire logic clk,
  input wire logic rst_n,
  sed_in_if.sink in_ch,
  sed_out_if.source out_ch
);
  import sed_pkg::*;

  job_t job_data;
  logic job_valid, job_ready;

  sed_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .job_data(job_data), .job_valid(job_valid), .job_ready(job_ready)
  );

  sed_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_data(job_data), .job_valid(job_valid), .job_ready(job_ready),
    .out_ch(out_ch)
  );

  a_zero_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && job_ready && job_data.zero_scale |=> u_back.qovf_r)
    else $error("zero scale lost");
  a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> 64'(out_ch.data.distance) * 64'(out_ch.data.distance)
      <= out_ch.data.squared_distance)
    else $error("root too large");
endmodule
`default_nettype wire
